// ----- src/pkd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkd_pkg - shared types and constants for the port knock detector
// Field widths, register indexes, queue item layout and sequencer states.
// ----------------------------------------------------------------------------
package pkd_pkg;

	localparam int DEF_CLIENT_SLOTS = 256;
	localparam int DEF_WINDOW_DEPTH = 8;

	// Configured sequence: up to eight 17-bit codes (bit 16 udp, 15:0 port)
	localparam int MAX_KNOCKS  = 8;
	localparam int KNOCK_CNT_W = 4;     // holds 0..MAX_KNOCKS
	localparam int KNOCK_J_W   = 3;     // holds 0..MAX_KNOCKS-1
	localparam int CODE_W      = 17;
	localparam int TIME_W      = 32;
	localparam int ENTRY_W     = CODE_W + TIME_W;
	localparam int SEQ_VEC_W   = CODE_W * MAX_KNOCKS;

	localparam int SLOT_IN_W   = 8;
	localparam int PORT_W      = 16;
	localparam int SEQ_LEN_W   = 4;
	localparam int TIMEOUT_W   = 16;
	localparam int KNOCKS_W    = 51;
	localparam int KNOCKS_LAST_W = 34;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 51;

	localparam logic [SEQ_LEN_W-1:0] SEQ_LEN_RESET   = 4'd3;
	localparam logic [TIMEOUT_W-1:0] GAP_LIMIT_RESET = 16'd25;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KNOCK_LEN     = 3'd0,
		REG_GAP_LIMIT     = 3'd1,
		REG_KNOCKS_FIRST  = 3'd2,
		REG_KNOCKS_MIDDLE = 3'd3,
		REG_KNOCKS_LAST   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [SLOT_IN_W-1:0] slot;
		logic                 in_range;
		logic [CODE_W-1:0]    code;
		logic [TIME_W-1:0]    stamp;
	} knock_item_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic        valid;
		knock_item_t item;
	} queue_head_t;

	// back end to front end
	typedef struct packed {
		logic pop;
		logic clearing;
	} back_ctrl_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PTR,
		ST_WALK,
		ST_FINISH
	} back_state_t;

endpackage

// ----- src/port_knock_sequence_detector_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_knock_sequence_detector_top - port knock sequence matcher
// Per-client knock windows compared against one configured knock sequence.
// ----------------------------------------------------------------------------
// Each knock names a client slot, a port with its TCP/UDP flag and the time
// in seconds; each gives exactly one result item carrying the slot and a
// matched flag. After reset the block clears the per-client pointer memory
// and holds knock_stall high meanwhile; the config port is live throughout.
// In the back end a knock steps through queue pop and pointer read, store,
// one window entry read per cycle for each entry of the effective sequence
// length (the configured length capped at eight and at the window depth),
// a check of the last entry and result load, so the window memory's single
// read port sets the sustained rate. An out-of-range slot or zero length
// takes only pop, pointer step and result load. A two-item queue in front
// lets knocks be taken while the back end works, and the result register
// lets the back end walk the next knock while the previous result is still
// stalled.
// Window entries are never cleared in place: a per-client write pointer and
// full flag mark which entries have been written since reset or the last
// match, and unwritten entries read as TCP port 0 at time 0.
// The user must write registers only while no knock is in flight: not enforced.
// ----------------------------------------------------------------------------
module port_knock_sequence_detector_top #(
	parameter int CLIENT_SLOTS = pkd_pkg::DEF_CLIENT_SLOTS,
	parameter int WINDOW_DEPTH = pkd_pkg::DEF_WINDOW_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_wr_en,
	input  logic [pkd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [pkd_pkg::CFG_DATA_W-1:0]   cfg_data,
	// knock channel
	input  logic                             knock_valid,
	output logic                             knock_stall,
	input  logic [pkd_pkg::SLOT_IN_W-1:0]    client_slot,
	input  logic [pkd_pkg::PORT_W-1:0]       port,
	input  logic                             is_udp,
	input  logic [pkd_pkg::TIME_W-1:0]       now_seconds,
	// result channel
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [pkd_pkg::SLOT_IN_W-1:0]    client_id,
	output logic                             matched
);

	logic [pkd_pkg::SEQ_LEN_W-1:0]     knock_len_q;
	logic [pkd_pkg::TIMEOUT_W-1:0]     gap_limit_q;
	logic [pkd_pkg::KNOCKS_W-1:0]      knocks_first_q;
	logic [pkd_pkg::KNOCKS_W-1:0]      knocks_middle_q;
	logic [pkd_pkg::KNOCKS_LAST_W-1:0] knocks_last_q;
	logic [pkd_pkg::SEQ_VEC_W-1:0]     seq_codes;

	pkd_pkg::queue_head_t              head;
	pkd_pkg::back_ctrl_t               ctrl;

	// config registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knock_len_q     <= pkd_pkg::SEQ_LEN_RESET;
			gap_limit_q     <= pkd_pkg::GAP_LIMIT_RESET;
			knocks_first_q  <= '0;
			knocks_middle_q <= '0;
			knocks_last_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				pkd_pkg::REG_KNOCK_LEN: begin
					knock_len_q <= cfg_data[pkd_pkg::SEQ_LEN_W-1:0];
				end
				pkd_pkg::REG_GAP_LIMIT: begin
					gap_limit_q <= cfg_data[pkd_pkg::TIMEOUT_W-1:0];
				end
				pkd_pkg::REG_KNOCKS_FIRST: begin
					knocks_first_q <= cfg_data[pkd_pkg::KNOCKS_W-1:0];
				end
				pkd_pkg::REG_KNOCKS_MIDDLE: begin
					knocks_middle_q <= cfg_data[pkd_pkg::KNOCKS_W-1:0];
				end
				pkd_pkg::REG_KNOCKS_LAST: begin
					knocks_last_q <= cfg_data[pkd_pkg::KNOCKS_LAST_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// knock k of the sequence lands at bits 17*k and up
	assign seq_codes = {knocks_last_q, knocks_middle_q, knocks_first_q};

	// front end: intake, slot range tag, two-entry queue
	pkd_front #(
		.CLIENT_SLOTS (CLIENT_SLOTS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.knock_valid (knock_valid),
		.knock_stall (knock_stall),
		.client_slot (client_slot),
		.port        (port),
		.is_udp      (is_udp),
		.now_seconds (now_seconds),
		.head        (head),
		.ctrl        (ctrl)
	);

	// back end: window store, sequence walk, result register
	pkd_back #(
		.CLIENT_SLOTS (CLIENT_SLOTS),
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.ctrl         (ctrl),
		.knock_len    (knock_len_q),
		.gap_limit    (gap_limit_q),
		.seq_codes    (seq_codes),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.client_id    (client_id),
		.matched      (matched)
	);

endmodule

// ----- src/pkd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkd_front - knock intake and queue
// Accepts knocks, tags out-of-range slots, packs the code and holds items in
// a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module pkd_front #(
	parameter int CLIENT_SLOTS = pkd_pkg::DEF_CLIENT_SLOTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           knock_valid,
	output logic                           knock_stall,
	input  logic [pkd_pkg::SLOT_IN_W-1:0]  client_slot,
	input  logic [pkd_pkg::PORT_W-1:0]     port,
	input  logic                           is_udp,
	input  logic [pkd_pkg::TIME_W-1:0]     now_seconds,
	output pkd_pkg::queue_head_t           head,
	input  pkd_pkg::back_ctrl_t            ctrl
);

	pkd_pkg::knock_item_t              q_mem_q [pkd_pkg::QUEUE_DEPTH];
	logic [pkd_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [pkd_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [pkd_pkg::QCNT_W-1:0]        count_q;
	logic                              push;
	logic                              full;
	pkd_pkg::knock_item_t              new_item;

	assign full        = (count_q == pkd_pkg::QCNT_W'(pkd_pkg::QUEUE_DEPTH));
	assign knock_stall = full || ctrl.clearing;
	assign push        = knock_valid && !knock_stall;

	always_comb begin
		new_item.slot     = client_slot;
		new_item.in_range = (32'(client_slot) < 32'(CLIENT_SLOTS));
		new_item.code     = {is_udp, port};
		new_item.stamp    = now_seconds;
	end

	assign head.valid = (count_q != '0);
	assign head.item  = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == pkd_pkg::QPTR_W'(pkd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (ctrl.pop) begin
				rd_ptr_q <= (rd_ptr_q == pkd_pkg::QPTR_W'(pkd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !ctrl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && ctrl.pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pkd_pkg::QCNT_W'(pkd_pkg::QUEUE_DEPTH))
		else $error("queue count above depth");

	a_no_intake_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clearing |-> !push)
		else $error("knock taken during clearing pass");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> head.valid)
		else $error("pop from empty queue");

endmodule

// ----- src/pkd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkd_back - knock window sequencer
// Holds per-client write pointers and knock windows, stores each knock,
// walks the newest entries against the sequence and drives the result item.
// ----------------------------------------------------------------------------
module pkd_back #(
	parameter int CLIENT_SLOTS = pkd_pkg::DEF_CLIENT_SLOTS,
	parameter int WINDOW_DEPTH = pkd_pkg::DEF_WINDOW_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pkd_pkg::queue_head_t             head,
	output pkd_pkg::back_ctrl_t              ctrl,
	input  logic [pkd_pkg::SEQ_LEN_W-1:0]    knock_len,
	input  logic [pkd_pkg::TIMEOUT_W-1:0]    gap_limit,
	input  logic [pkd_pkg::SEQ_VEC_W-1:0]    seq_codes,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [pkd_pkg::SLOT_IN_W-1:0]    client_id,
	output logic                             matched
);

	localparam int SLOT_W      = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
	localparam int IDX_W       = $clog2(WINDOW_DEPTH);
	localparam int CTX_W       = IDX_W + 1;
	localparam int WIN_ENTRIES = CLIENT_SLOTS * (2 ** IDX_W);
	localparam int SUM_W       = IDX_W + 2;

	// per-client context: {full, write pointer}; window entry: {code, time}
	logic [CTX_W-1:0]                 ctx_mem [CLIENT_SLOTS];
	logic [pkd_pkg::ENTRY_W-1:0]      win_mem [WIN_ENTRIES];

	pkd_pkg::back_state_t             state_q, state_d;
	logic [SLOT_W-1:0]                clr_q;
	pkd_pkg::knock_item_t             item_q;
	logic [CTX_W-1:0]                 ctx_rd_q;
	logic [IDX_W-1:0]                 wp_q;
	logic                             full_q;
	logic [pkd_pkg::KNOCK_CNT_W-1:0]  len_q;
	logic                             ok_q;
	logic [IDX_W-1:0]                 rd_idx_q;
	logic [pkd_pkg::KNOCK_CNT_W-1:0]  iss_j_q;
	logic                             rd_vld_s1;
	logic [pkd_pkg::KNOCK_J_W-1:0]    chk_j_s1;
	logic [IDX_W-1:0]                 chk_idx_s1;
	logic [pkd_pkg::ENTRY_W-1:0]      win_rd_s1;
	logic [pkd_pkg::TIME_W-1:0]       prev_time_q;
	logic                             result_valid_q;
	logic [pkd_pkg::SLOT_IN_W-1:0]    client_id_q;
	logic                             matched_q;

	logic [SLOT_W-1:0]                slot_idx;
	logic [SLOT_W-1:0]                head_slot_idx;
	logic [IDX_W-1:0]                 ctx_wp;
	logic                             ctx_full;
	logic [IDX_W-1:0]                 wp_next;
	logic                             full_next;
	logic [pkd_pkg::KNOCK_CNT_W-1:0]  len_cap;
	logic [pkd_pkg::KNOCK_CNT_W-1:0]  len_eff;
	logic [SUM_W-1:0]                 start_sum;
	logic [IDX_W-1:0]                 start_idx;
	logic                             ent_valid;
	logic [pkd_pkg::CODE_W-1:0]       ent_code;
	logic [pkd_pkg::TIME_W-1:0]       ent_time;
	logic [pkd_pkg::CODE_W-1:0]       want_code;
	logic [pkd_pkg::TIME_W-1:0]       gap;
	logic                             hit;
	logic                             issue;
	logic                             last_chk;
	logic                             out_free;
	logic                             out_load;
	logic                             win_we;
	logic                             ctx_we;
	logic [SLOT_W-1:0]                ctx_waddr;
	logic [CTX_W-1:0]                 ctx_wdata;

	assign slot_idx      = SLOT_W'(item_q.slot);
	assign head_slot_idx = SLOT_W'(head.item.slot);
	assign ctx_wp        = ctx_rd_q[IDX_W-1:0];
	assign ctx_full      = ctx_rd_q[IDX_W];
	assign wp_next       = (ctx_wp == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : ctx_wp + 1'b1;
	assign full_next     = ctx_full || (ctx_wp == IDX_W'(WINDOW_DEPTH - 1));

	// effective length: capped at the sequence size and the window depth
	always_comb begin
		len_cap = (knock_len > pkd_pkg::KNOCK_CNT_W'(pkd_pkg::MAX_KNOCKS)) ?
			pkd_pkg::KNOCK_CNT_W'(pkd_pkg::MAX_KNOCKS) : knock_len;
		len_eff = (32'(len_cap) > 32'(WINDOW_DEPTH)) ?
			pkd_pkg::KNOCK_CNT_W'(WINDOW_DEPTH) : len_cap;
	end

	// oldest entry of the walk: (wp + depth - len) mod depth, value below 2*depth
	always_comb begin
		start_sum = SUM_W'(wp_next) + SUM_W'(WINDOW_DEPTH) - SUM_W'(len_eff);
		if (start_sum >= SUM_W'(WINDOW_DEPTH)) begin
			start_idx = IDX_W'(start_sum - SUM_W'(WINDOW_DEPTH));
		end else begin
			start_idx = IDX_W'(start_sum);
		end
	end

	// entries past the fill mark read as cleared (TCP port 0 at time 0)
	always_comb begin
		ent_valid = full_q || (chk_idx_s1 < wp_q);
		ent_code  = ent_valid ? win_rd_s1[pkd_pkg::ENTRY_W-1:pkd_pkg::TIME_W] : '0;
		ent_time  = ent_valid ? win_rd_s1[pkd_pkg::TIME_W-1:0] : '0;
		want_code = seq_codes[pkd_pkg::CODE_W*chk_j_s1 +: pkd_pkg::CODE_W];
		gap       = (chk_j_s1 == '0) ? '0 : ent_time - prev_time_q;
		hit       = (ent_code == want_code) && (gap <= pkd_pkg::TIME_W'(gap_limit));
	end

	assign issue    = (state_q == pkd_pkg::ST_WALK) && (iss_j_q < len_q);
	assign last_chk = rd_vld_s1 &&
		(pkd_pkg::KNOCK_CNT_W'(chk_j_s1) == len_q - 1'b1);
	assign out_free = !result_valid_q || !result_stall;

	always_comb begin
		state_d       = state_q;
		ctrl.pop      = 1'b0;
		ctrl.clearing = 1'b0;
		out_load      = 1'b0;
		win_we        = 1'b0;
		ctx_we        = 1'b0;
		ctx_waddr     = slot_idx;
		ctx_wdata     = '0;
		unique case (state_q)
			pkd_pkg::ST_CLEAR: begin
				ctrl.clearing = 1'b1;
				ctx_we        = 1'b1;
				ctx_waddr     = clr_q;
				if (clr_q == SLOT_W'(CLIENT_SLOTS - 1)) begin
					state_d = pkd_pkg::ST_IDLE;
				end
			end
			pkd_pkg::ST_IDLE: begin
				if (head.valid) begin
					ctrl.pop = 1'b1;
					state_d  = pkd_pkg::ST_PTR;
				end
			end
			pkd_pkg::ST_PTR: begin
				if (item_q.in_range) begin
					win_we    = 1'b1;
					ctx_we    = 1'b1;
					ctx_wdata = {full_next, wp_next};
				end
				if (!item_q.in_range || (len_eff == '0)) begin
					state_d = pkd_pkg::ST_FINISH;
				end else begin
					state_d = pkd_pkg::ST_WALK;
				end
			end
			pkd_pkg::ST_WALK: begin
				if (last_chk) begin
					state_d = pkd_pkg::ST_FINISH;
				end
			end
			pkd_pkg::ST_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					ctx_we   = ok_q;
					state_d  = pkd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pkd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pkd_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// context memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctx_we) begin
			ctx_mem[ctx_waddr] <= ctx_wdata;
		end
		if (ctrl.pop) begin
			ctx_rd_q <= ctx_mem[head_slot_idx];
		end
	end

	// window memory
	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[{slot_idx, ctx_wp}] <= {item_q.code, item_q.stamp};
		end
		if (issue) begin
			win_rd_s1 <= win_mem[{slot_idx, rd_idx_q}];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			item_q <= head.item;
		end
		if (state_q == pkd_pkg::ST_PTR) begin
			wp_q     <= wp_next;
			full_q   <= full_next;
			len_q    <= len_eff;
		end
		if (issue) begin
			chk_j_s1   <= iss_j_q[pkd_pkg::KNOCK_J_W-1:0];
			chk_idx_s1 <= rd_idx_q;
		end
		if (rd_vld_s1) begin
			prev_time_q <= ent_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			ok_q      <= 1'b0;
			rd_idx_q  <= '0;
			iss_j_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (state_q == pkd_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == pkd_pkg::ST_PTR) begin
				ok_q      <= item_q.in_range && (len_eff != '0);
				rd_idx_q  <= start_idx;
				iss_j_q   <= '0;
				rd_vld_s1 <= 1'b0;
			end else if (state_q == pkd_pkg::ST_WALK) begin
				rd_vld_s1 <= issue;
				if (issue) begin
					iss_j_q  <= iss_j_q + 1'b1;
					rd_idx_q <= (rd_idx_q == IDX_W'(WINDOW_DEPTH - 1)) ?
						'0 : rd_idx_q + 1'b1;
				end
				if (rd_vld_s1) begin
					ok_q <= ok_q && hit;
				end
			end else begin
				rd_vld_s1 <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			client_id_q <= item_q.slot;
			matched_q   <= ok_q;
		end
	end

	assign result_valid = result_valid_q;
	assign client_id    = client_id_q;
	assign matched      = matched_q;

	a_match_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && ok_q |-> item_q.in_range)
		else $error("match reported for out-of-range slot");

	a_match_clears_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && ok_q |-> ctx_we && (ctx_waddr == slot_idx) && (ctx_wdata == '0))
		else $error("matched client context not cleared");

	a_check_in_len: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 && (state_q == pkd_pkg::ST_WALK) |->
		pkd_pkg::KNOCK_CNT_W'(chk_j_s1) < len_q)
		else $error("window walk ran past sequence length");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != pkd_pkg::ST_CLEAR |=> state_q != pkd_pkg::ST_CLEAR)
		else $error("clearing pass re-entered");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for port_knock_sequence_detector_top
// Drives knock items through the valid/stall channel, mirrors the per-client
// knock windows in a local predictor and checks every result item in order.
// ----------------------------------------------------------------------------
// A short directed run covers the extreme field values, wrapping time stamps,
// cleared window entries, zero and oversized sequence lengths and a write to
// an unmapped register. Six random phases follow, each with its own sequence
// setup and idling mix. Most knocks walk a small pool of clients through the
// configured sequence with gaps inside the timeout. The rest are noise, knocks
// out of order and gaps just past the timeout. One phase parks the result side
// long enough to back the block up, another drains fully halfway through.
// ----------------------------------------------------------------------------
module tb;

	localparam int SLOT_IN_W     = pkd_pkg::SLOT_IN_W;
	localparam int PORT_W        = pkd_pkg::PORT_W;
	localparam int TIME_W        = pkd_pkg::TIME_W;
	localparam int CODE_W        = pkd_pkg::CODE_W;
	localparam int CFG_INDEX_W   = pkd_pkg::CFG_INDEX_W;
	localparam int CFG_DATA_W    = pkd_pkg::CFG_DATA_W;
	localparam int SEQ_LEN_W     = pkd_pkg::SEQ_LEN_W;
	localparam int TIMEOUT_W     = pkd_pkg::TIMEOUT_W;
	localparam int KNOCKS_W      = pkd_pkg::KNOCKS_W;
	localparam int KNOCKS_LAST_W = pkd_pkg::KNOCKS_LAST_W;
	localparam int MAX_KNOCKS    = pkd_pkg::MAX_KNOCKS;
	localparam int SLOTS         = pkd_pkg::DEF_CLIENT_SLOTS;
	localparam int DEPTH         = pkd_pkg::DEF_WINDOW_DEPTH;

	localparam int          STUCK_LIMIT      = 4000; // cycles with no handshake at all
	localparam int          LONG_HOLD_CYCLES = 300;
	localparam int          PHASE_ITEMS      = 104;
	localparam int          POOL             = 4;    // clients walked per random phase
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

	// directed sequence codes: bit 16 udp, bits 15:0 port
	localparam logic [CODE_W-1:0] CODE_A = {1'b1, 16'd1000};
	localparam logic [CODE_W-1:0] CODE_B = {1'b0, 16'd2000};
	localparam logic [CODE_W-1:0] CODE_C = {1'b1, 16'hFFFF};

	typedef struct {
		logic [SLOT_IN_W-1:0] slot;
		logic [PORT_W-1:0]    port;
		logic                 udp;
		logic [TIME_W-1:0]    stamp;
	} knock_t;

	typedef struct {
		logic [SLOT_IN_W-1:0] client;
		logic                 matched;
	} verdict_t;

	// every block input is known from time zero
	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   cfg_wr_en    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;
	logic                   knock_valid  = 1'b0;
	logic                   knock_stall;
	logic [SLOT_IN_W-1:0]   client_slot  = '0;
	logic [PORT_W-1:0]      port         = '0;
	logic                   is_udp       = 1'b0;
	logic [TIME_W-1:0]      now_seconds  = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic [SLOT_IN_W-1:0]   client_id;
	logic                   matched;

	port_knock_sequence_detector_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.knock_valid  (knock_valid),
		.knock_stall  (knock_stall),
		.client_slot  (client_slot),
		.port         (port),
		.is_udp       (is_udp),
		.now_seconds  (now_seconds),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.client_id    (client_id),
		.matched      (matched)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Mirror of the block: register copies plus per-client knock windows.
	// bit types start at zero, which is the cleared state after reset.
	// ------------------------------------------------------------------
	logic [SEQ_LEN_W-1:0]     cfg_len     = pkd_pkg::SEQ_LEN_RESET;
	logic [TIMEOUT_W-1:0]     cfg_timeout = pkd_pkg::GAP_LIMIT_RESET;
	logic [KNOCKS_W-1:0]      cfg_first   = '0;
	logic [KNOCKS_W-1:0]      cfg_middle  = '0;
	logic [KNOCKS_LAST_W-1:0] cfg_last    = '0;

	bit [CODE_W-1:0] ring_code [SLOTS][DEPTH];
	bit [TIME_W-1:0] ring_time [SLOTS][DEPTH];
	int unsigned     ring_wp   [SLOTS];

	knock_t   knock_q[$];    // items waiting for the driver
	verdict_t verdict_q[$];  // outcomes of accepted knocks, oldest first

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_reqs      = 0; // bumped to ask the result side for a long hold
	int unsigned mismatches     = 0;
	int unsigned stuck_cycles   = 0;

	// code of knock k of the configured sequence
	function automatic logic [CODE_W-1:0] knock_code(input int unsigned k);
		logic [KNOCKS_W-1:0] bank;
		if (k < 3)
			bank = cfg_first;
		else if (k < 6)
			bank = cfg_middle;
		else
			bank = KNOCKS_W'(cfg_last);
		return bank[CODE_W*(k%3) +: CODE_W];
	endfunction

	// Store the knock, then test the newest entries against the sequence.
	// Returns the matched flag; a match wipes that client's window.
	function automatic bit knock_completes(input logic [SLOT_IN_W-1:0] slot,
			input logic [CODE_W-1:0] code, input logic [TIME_W-1:0] stamp);
		int unsigned      len;
		int unsigned      first;
		int unsigned      cur;
		int unsigned      prev;
		logic [TIME_W-1:0] gap;
		bit               hit;
		ring_code[slot][ring_wp[slot]] = code;
		ring_time[slot][ring_wp[slot]] = stamp;
		ring_wp[slot] = (ring_wp[slot] + 1) % DEPTH;
		len = 32'(cfg_len);
		if (len > MAX_KNOCKS)
			len = MAX_KNOCKS;
		if (len > DEPTH)
			len = DEPTH;
		if (len == 0)
			return 1'b0;
		first = (ring_wp[slot] + DEPTH - len) % DEPTH;
		hit = 1'b1;
		for (int j = 0; j < len; j++) begin
			cur  = (first + j) % DEPTH;
			// first knock of the sequence is compared with itself: gap 0
			prev = (first + ((j != 0) ? j - 1 : 0)) % DEPTH;
			gap  = ring_time[slot][cur] - ring_time[slot][prev];
			if (ring_code[slot][cur] != knock_code(j) || gap > TIME_W'(cfg_timeout))
				hit = 1'b0;
		end
		if (hit) begin
			for (int e = 0; e < DEPTH; e++) begin
				ring_code[slot][e] = '0;
				ring_time[slot][e] = '0;
			end
			ring_wp[slot] = 0;
		end
		return hit;
	endfunction

	// ------------------------------------------------------------------
	// Knock driver: a new item goes out only when the channel is free,
	// so a stalled payload never moves.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive_knocks
		knock_t nxt;
		if (arst_n && (!knock_valid || !knock_stall)) begin
			if (knock_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = knock_q.pop_front();
				knock_valid <= 1'b1;
				client_slot <= nxt.slot;
				port        <= nxt.port;
				is_udp      <= nxt.udp;
				now_seconds <= nxt.stamp;
			end else begin
				knock_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side stall. A long hold is counted here so the knock side
	// keeps offering items while results back up.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive_stall
		int unsigned hold_left;
		int unsigned hold_seen;
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = LONG_HOLD_CYCLES;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Scoreboard: check the result first, then log the accepted knock,
	// so a stray result can never pair with a knock of the same edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : score
		verdict_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (verdict_q.size() == 0) begin
					mismatches++;
					$error("result for client %0d with no knock outstanding", client_id);
				end else begin
					want = verdict_q.pop_front();
					if (client_id !== want.client) begin
						mismatches++;
						$error("client_id: expected %0d, actual %0d", want.client, client_id);
					end
					if (matched !== want.matched) begin
						mismatches++;
						$error("matched: expected %0b, actual %0b", want.matched, matched);
					end
				end
			end
			if (knock_valid && !knock_stall) begin
				want.client  = client_slot;
				want.matched = knock_completes(client_slot, {is_udp, port}, now_seconds);
				verdict_q.push_back(want);
			end
		end
	end

	// Watchdog: any handshake restarts the count; covers the clearing
	// pass after reset and the long result hold with room to spare.
	always @(posedge clk) begin
		if (!arst_n || (knock_valid && !knock_stall) || (result_valid && !result_stall)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [CFG_DATA_W-1:0] rand51();
		return CFG_DATA_W'({$urandom, $urandom});
	endfunction

	// value in the low bits, junk above the register width
	function automatic logic [CFG_DATA_W-1:0] salted(input logic [CFG_DATA_W-1:0] value,
			input int unsigned width);
		logic [CFG_DATA_W-1:0] mask;
		mask = {CFG_DATA_W{1'b1}} << width;
		return (rand51() & mask) | (value & ~mask);
	endfunction

	task automatic add_knock(input logic [SLOT_IN_W-1:0] slot, input logic [CODE_W-1:0] code,
			input logic [TIME_W-1:0] stamp);
		knock_t k;
		k.slot  = slot;
		k.port  = code[PORT_W-1:0];
		k.udp   = code[CODE_W-1];
		k.stamp = stamp;
		knock_q.push_back(k);
	endtask

	// Settled at the falling edge: nothing queued, nothing offered, and
	// every accepted knock has had its result. Each knock yields exactly
	// one result, so the block is idle from here on.
	task automatic wait_drained();
		@(negedge clk);
		while (knock_q.size() != 0 || knock_valid || verdict_q.size() != 0)
			@(negedge clk);
	endtask

	// one register write; the mirror follows with the block's masking
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			pkd_pkg::REG_KNOCK_LEN:     cfg_len     = data[SEQ_LEN_W-1:0];
			pkd_pkg::REG_GAP_LIMIT:     cfg_timeout = data[TIMEOUT_W-1:0];
			pkd_pkg::REG_KNOCKS_FIRST:  cfg_first   = data[KNOCKS_W-1:0];
			pkd_pkg::REG_KNOCKS_MIDDLE: cfg_middle  = data[KNOCKS_W-1:0];
			pkd_pkg::REG_KNOCKS_LAST:   cfg_last    = data[KNOCKS_LAST_W-1:0];
			default: ;  // unmapped index: no effect
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Random knocks: mostly a pool of clients walking the sequence,
	// plus noise, out-of-order codes and gaps just past the timeout.
	task automatic knock_burst(input int unsigned count, input bit pause_mid,
			input bit long_hold);
		int unsigned          seq_n;
		int unsigned          pick;
		int unsigned          roll;
		logic [TIME_W-1:0]    gap;
		logic [CODE_W-1:0]    code;
		int unsigned          progress [POOL];
		logic [SLOT_IN_W-1:0] who [POOL];
		logic [TIME_W-1:0]    clock_at [POOL];
		seq_n = (cfg_len > MAX_KNOCKS) ? MAX_KNOCKS : 32'(cfg_len);
		for (int i = 0; i < POOL; i++) begin
			progress[i] = 0;
			who[i]      = SLOT_IN_W'($urandom_range(255));
			clock_at[i] = $urandom;
		end
		for (int k = 0; k < count; k++) begin
			// sender pause: let every outstanding result come home
			if (pause_mid && k == count / 2)
				wait_drained();
			// enough items are queued by now to keep the knock side busy
			if (long_hold && k == 24)
				hold_reqs++;
			pick = $urandom_range(POOL - 1);
			roll = $urandom_range(99);
			if (roll < 8) begin
				// stray knock from anywhere
				add_knock(SLOT_IN_W'($urandom_range(255)), CODE_W'($urandom), $urandom);
			end else begin
				if (roll < 18) begin
					// wrong-order or random code, arbitrary gap
					code = (roll < 13) ? knock_code($urandom_range(seq_n - 1))
						: CODE_W'($urandom);
					gap = $urandom;
					progress[pick] = 0;
				end else if (roll < 23) begin
					// right code, gap just over the limit
					code = knock_code(progress[pick]);
					gap = TIME_W'(cfg_timeout) + 1 + $urandom_range(3);
					progress[pick] = 0;
				end else begin
					code = knock_code(progress[pick]);
					gap = (roll < 40) ? TIME_W'(cfg_timeout)
						: TIME_W'($urandom_range(cfg_timeout));
					progress[pick] = (progress[pick] + 1) % seq_n;
				end
				clock_at[pick] += gap;
				add_knock(who[pick], code, clock_at[pick]);
			end
		end
	endtask

	task automatic run_phase(input logic [SEQ_LEN_W-1:0] len,
			input logic [TIMEOUT_W-1:0] window_s, input int unsigned idle,
			input int unsigned stall, input bit pause_mid, input bit long_hold);
		wait_drained();
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		write_reg(pkd_pkg::REG_KNOCK_LEN, salted(len, SEQ_LEN_W));
		write_reg(pkd_pkg::REG_GAP_LIMIT, salted(window_s, TIMEOUT_W));
		write_reg(pkd_pkg::REG_KNOCKS_FIRST, rand51());
		write_reg(pkd_pkg::REG_KNOCKS_MIDDLE, rand51());
		write_reg(pkd_pkg::REG_KNOCKS_LAST, rand51());
		knock_burst(PHASE_ITEMS, pause_mid, long_hold);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [TIME_W-1:0] t;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset setup: length 3, timeout 25, all codes TCP port 0.
		// Cleared entries count as TCP 0 at time 0, so a lone TCP 0 knock
		// at a small time completes the sequence on a fresh client.
		add_knock(8'd0, '0, 32'd0);
		add_knock(8'd1, {1'b1, 16'hFFFF}, 32'hFFFF_FFFF);
		add_knock(8'd255, '0, 32'd5);
		add_knock(8'd2, '0, 32'd100);      // gap from cleared entry too big

		wait_drained();
		write_reg(pkd_pkg::REG_KNOCK_LEN, salted(4'd3, SEQ_LEN_W));
		write_reg(pkd_pkg::REG_GAP_LIMIT, salted(16'd10, TIMEOUT_W));
		write_reg(pkd_pkg::REG_KNOCKS_FIRST, {CODE_C, CODE_B, CODE_A});
		// gaps of 8 across the time wrap and exactly the timeout: match
		add_knock(8'd3, CODE_A, 32'hFFFF_FFFA);
		add_knock(8'd3, CODE_B, 32'h0000_0002);
		add_knock(8'd3, CODE_C, 32'h0000_000C);
		// last gap one past the timeout
		add_knock(8'd4, CODE_A, 32'd50);
		add_knock(8'd4, CODE_B, 32'd60);
		add_knock(8'd4, CODE_C, 32'd71);
		// right port, wrong protocol on the last knock
		add_knock(8'd5, CODE_A, 32'd7);
		add_knock(8'd5, CODE_B, 32'd8);
		add_knock(8'd5, {1'b0, CODE_C[PORT_W-1:0]}, 32'd9);

		// zero length never matches, knocks are still stored
		wait_drained();
		write_reg(pkd_pkg::REG_KNOCK_LEN, salted(4'd0, SEQ_LEN_W));
		add_knock(8'd6, CODE_A, 32'd0);
		add_knock(8'd6, CODE_A, 32'd1);

		// length 15 acts as 8; widest timeout; unmapped writes are ignored
		wait_drained();
		write_reg(pkd_pkg::REG_KNOCK_LEN, salted(4'd15, SEQ_LEN_W));
		write_reg(pkd_pkg::REG_GAP_LIMIT, salted(16'hFFFF, TIMEOUT_W));
		write_reg(pkd_pkg::REG_KNOCKS_MIDDLE, rand51());
		write_reg(pkd_pkg::REG_KNOCKS_LAST, rand51());
		write_reg(REG_UNMAPPED, {CFG_DATA_W{1'b1}});
		t = 32'hFFFF_0000;
		for (int k = 0; k < MAX_KNOCKS; k++) begin
			add_knock(8'd7, knock_code(k), t);
			t += 32'd65535;
		end

		// one-knock sequence with the tightest timeout
		wait_drained();
		write_reg(pkd_pkg::REG_KNOCK_LEN, salted(4'd1, SEQ_LEN_W));
		write_reg(pkd_pkg::REG_GAP_LIMIT, salted(16'd1, TIMEOUT_W));
		add_knock(8'd8, CODE_A, 32'd12345);
		add_knock(8'd9, '0, 32'd12345);

		// random phases: length, timeout, sender idle %, stall %, pause, hold
		run_phase(4'd1, 16'd1, 0, 0, 1'b0, 1'b0);
		run_phase(4'd8, 16'hFFFF, 48, 0, 1'b0, 1'b0);
		run_phase(4'd15, TIMEOUT_W'($urandom_range(1, 65535)), 0, 48, 1'b0, 1'b1);
		run_phase(SEQ_LEN_W'($urandom_range(2, 7)), TIMEOUT_W'($urandom_range(1, 100)),
			7, 7, 1'b1, 1'b0);
		run_phase(SEQ_LEN_W'($urandom_range(1, 8)), TIMEOUT_W'($urandom_range(1, 65535)),
			0, 0, 1'b0, 1'b0);
		run_phase(4'd3, 16'd25, 7, 7, 1'b0, 1'b0);

		// drain, then give a late stray result time to show up
		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
